@@ src/modexp_pkg.sv @@
// Shared constants for the modular exponentiation block.
// No dependencies; imported by modular_exponentiation and its checker.
package modexp_pkg;

  // Port width of every data field.
  localparam int FIELD_W = 32;
  // Arithmetic width; fields are masked to this many bits (8..32).
  localparam int WIDTH   = 32;
  // Bit counter of the serial multiplier, holds WIDTH-1.
  localparam int CNT_W   = $clog2(WIDTH);

endpackage

@@ src/modular_exponentiation.sv @@
// A zero modulus or a zero exponent is answered straight from idle; otherwise the base
// is reduced, then k = popcount(e) + bit length(e) - 1 more multiplications, at most 63.
// Throughput: one request at a time; busy stays high until the result strobe.
// Rate is set by the bit-serial shift-add-reduce multiplier: one bit per cycle.
// Reset (rst_n low, synchronous) returns to idle and drops the result strobe.
// The result is shown for one cycle only; the receiver cannot stall it.
module modular_exponentiation
  import modexp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic [FIELD_W-1:0] in_base,
  input  logic [FIELD_W-1:0] in_exponent,
  input  logic [FIELD_W-1:0] in_modulus,
  // result channel
  output logic               out_valid,
  output logic [FIELD_W-1:0] out_power_mod,
  output logic               out_bad_modulus
);

  // S_RED: base mod n (base times 1 mod n), so later operands stay below n.
  // S_ACC: acc = acc * x mod n.  S_SQR: x = x * x mod n.
  typedef enum logic [1:0] {S_IDLE, S_RED, S_ACC, S_SQR} state_t;

  state_t             state_r, state_nxt;
  logic [WIDTH-1:0]   x_r, x_nxt;       // running base power
  logic [WIDTH-1:0]   e_r, e_nxt;       // remaining exponent
  logic [WIDTH-1:0]   m_r, m_nxt;       // modulus
  logic [WIDTH-1:0]   acc_r, acc_nxt;   // accumulator
  logic [WIDTH-1:0]   a_sh_r, a_sh_nxt; // multiplier operand, shifted out MSB first
  logic [WIDTH-1:0]   b_r, b_nxt;       // multiplicand, always below m
  logic [WIDTH-1:0]   r_r, r_nxt;       // partial remainder, always below m
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0]   out_pm_r, out_pm_nxt;
  logic               out_bad_r, out_bad_nxt;

  // One multiplier step: t = 2r + a_bit*b < 3m, then reduce by m or 2m.
  logic [WIDTH+1:0]   t_w, m1_w, m2_w, t_red;
  logic [WIDTH-1:0]   r_step;
  logic [WIDTH-1:0]   in_m, in_e, e_half;

  always_comb begin
    m1_w = {2'b00, m_r};
    m2_w = {1'b0, m_r, 1'b0};
    t_w  = {1'b0, r_r, 1'b0} + (a_sh_r[WIDTH-1] ? {2'b00, b_r} : '0);
    if (t_w >= m2_w) begin
      t_red = t_w - m2_w;
    end else if (t_w >= m1_w) begin
      t_red = t_w - m1_w;
    end else begin
      t_red = t_w;
    end
    r_step = t_red[WIDTH-1:0];
  end

  assign in_m   = in_modulus[WIDTH-1:0];
  assign in_e   = in_exponent[WIDTH-1:0];
  assign e_half = e_r >> 1;

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    e_nxt         = e_r;
    m_nxt         = m_r;
    acc_nxt       = acc_r;
    a_sh_nxt      = a_sh_r;
    b_nxt         = b_r;
    r_nxt         = r_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_pm_nxt    = out_pm_r;
    out_bad_nxt   = out_bad_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          x_nxt   = in_base[WIDTH-1:0];
          e_nxt   = in_e;
          m_nxt   = in_m;
          acc_nxt = WIDTH'(1);
          if (in_m == '0) begin
            // zero modulus: flag it, result 0
            out_valid_nxt = 1'b1;
            out_pm_nxt    = '0;
            out_bad_nxt   = 1'b1;
          end else if (in_e == '0) begin
            // zero exponent: 1, not reduced
            out_valid_nxt = 1'b1;
            out_pm_nxt    = WIDTH'(1);
            out_bad_nxt   = 1'b0;
          end else begin
            state_nxt = S_RED;
            a_sh_nxt  = in_base[WIDTH-1:0];
            b_nxt     = (in_m == WIDTH'(1)) ? '0 : WIDTH'(1);
            r_nxt     = '0;
            cnt_nxt   = CNT_W'(WIDTH - 1);
          end
        end
      end
      S_RED, S_ACC, S_SQR: begin
        a_sh_nxt = a_sh_r << 1;
        r_nxt    = r_step;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          r_nxt   = '0;
          cnt_nxt = CNT_W'(WIDTH - 1);
          if (state_r == S_ACC) begin
            // odd step done: e-1, then halve if anything is left
            acc_nxt = r_step;
            if (e_half == '0) begin
              state_nxt     = S_IDLE;
              out_valid_nxt = 1'b1;
              out_pm_nxt    = r_step;
              out_bad_nxt   = 1'b0;
            end else begin
              state_nxt = S_SQR;
              e_nxt     = e_half;
              a_sh_nxt  = x_r;
              b_nxt     = x_r;
            end
          end else begin
            // new x ready; e is nonzero here
            x_nxt = r_step;
            if (e_r[0]) begin
              state_nxt = S_ACC;
              a_sh_nxt  = acc_r;
              b_nxt     = r_step;
            end else begin
              state_nxt = S_SQR;
              e_nxt     = e_half;
              a_sh_nxt  = r_step;
              b_nxt     = r_step;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r       <= x_nxt;
    e_r       <= e_nxt;
    m_r       <= m_nxt;
    acc_r     <= acc_nxt;
    a_sh_r    <= a_sh_nxt;
    b_r       <= b_nxt;
    r_r       <= r_nxt;
    cnt_r     <= cnt_nxt;
    out_pm_r  <= out_pm_nxt;
    out_bad_r <= out_bad_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_power_mod   = FIELD_W'(out_pm_r);
  assign out_bad_modulus = out_bad_r;

endmodule

@@ src/modexp_checker.sv @@
// Port-level checker for modular_exponentiation, with its bind.
// Depends on modexp_pkg.
module modexp_checker
  import modexp_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [FIELD_W-1:0] in_exponent,
  input logic [FIELD_W-1:0] in_modulus,
  input logic               out_valid,
  input logic [FIELD_W-1:0] out_power_mod,
  input logic               out_bad_modulus
);

  logic [WIDTH-1:0] mod_w, exp_w;
  assign mod_w = in_modulus[WIDTH-1:0];
  assign exp_w = in_exponent[WIDTH-1:0];

  // zero modulus answers next cycle with the flag and a zero result
  a_zero_mod: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && mod_w == '0) |=>
      (out_valid && out_bad_modulus && out_power_mod == '0))
    else $error("zero modulus request not answered with error");

  // zero exponent answers next cycle with 1
  a_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && mod_w != '0 && exp_w == '0) |=>
      (out_valid && !out_bad_modulus && out_power_mod == FIELD_W'(1)))
    else $error("zero exponent request not answered with 1");

  // a real exponentiation goes busy and gives no result yet
  a_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && mod_w != '0 && exp_w != '0) |=> (busy && !out_valid))
    else $error("exponentiation request did not start");

  // leaving busy always comes with the result strobe
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> (out_valid && !out_bad_modulus))
    else $error("busy dropped without a result");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (.*);
